### design/assert_macros.svh
// Assertion helpers shared by the tracker modules; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define OLPT_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define OLPT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

### design/olpt_pkg.sv
package olpt_pkg;

	localparam int OLPT_MAX_POINTS = 256;
	localparam int CORDIC_STEPS = 20;
	localparam int NUM_W = 54;
	localparam logic [64:0] GOAL_D2 = 65'd429496;
	localparam logic [64:0] NEAR_D2 = 65'd43;
	localparam logic signed [30:0] INV_GAIN = 31'sd652032874;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_NOP    = 2'd3
	} olpt_kind_t;

	typedef enum logic [2:0] {
		REG_DESIRED_SPEED  = 3'd0,
		REG_SPEED_SCALE    = 3'd1,
		REG_LOOKAHEAD_DIST = 3'd2,
		REG_MAX_X_SPEED    = 3'd3,
		REG_MAX_Y_SPEED    = 3'd4
	} olpt_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_DIFF,
		ST_SQ,
		ST_EVAL,
		ST_SQRT,
		ST_MUL,
		ST_DIV,
		ST_ROT,
		ST_CORDIC,
		ST_GAIN,
		ST_RND,
		ST_OUT
	} olpt_state_t;

	typedef enum logic [1:0] {
		PH_GOAL,
		PH_FIRST,
		PH_NEAR,
		PH_LOOK
	} olpt_phase_t;

	typedef struct packed {
		olpt_kind_t         kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
	} olpt_item_t;

	typedef struct packed {
		logic [20:0] desired_speed;
		logic [16:0] speed_scale;
		logic [23:0] lookahead_dist;
		logic [20:0] max_x_speed;
		logic [20:0] max_y_speed;
	} olpt_cfg_t;

	function automatic olpt_kind_t olpt_classify(input logic [1:0] req);
		olpt_kind_t k;
		case (req)
			2'd0: k = KIND_CLEAR;
			2'd1: k = KIND_APPEND;
			2'd2: k = KIND_QUERY;
			default: k = KIND_NOP;
		endcase
		return k;
	endfunction

	function automatic logic signed [33:0] olpt_atan(input logic [4:0] i);
		logic signed [33:0] a;
		case (i)
			5'd0:  a = 34'sd536870912;
			5'd1:  a = 34'sd316933406;
			5'd2:  a = 34'sd167458907;
			5'd3:  a = 34'sd85004756;
			5'd4:  a = 34'sd42667331;
			5'd5:  a = 34'sd21354465;
			5'd6:  a = 34'sd10679838;
			5'd7:  a = 34'sd5340245;
			5'd8:  a = 34'sd2670163;
			5'd9:  a = 34'sd1335087;
			5'd10: a = 34'sd667544;
			5'd11: a = 34'sd333772;
			5'd12: a = 34'sd166886;
			5'd13: a = 34'sd83443;
			5'd14: a = 34'sd41722;
			5'd15: a = 34'sd20861;
			5'd16: a = 34'sd10430;
			5'd17: a = 34'sd5215;
			5'd18: a = 34'sd2608;
			5'd19: a = 34'sd1304;
			default: a = 34'sd0;
		endcase
		return a;
	endfunction

endpackage

### design/omni_lookahead_path_tracker.sv
// Lookahead path tracker for a holonomic base.
// Input stream (s_*): tuser = request (0 clear path, 1 append waypoint,
// 2 pose query, 3 ignored); tdata = x, y position and heading. Clear and
// append give no output; every query gives one transfer on m_*: body-frame
// velocity, target waypoint slot, and at-goal / no-path flags in tuser.
// Config port (cfg_*): index 0..4 = desired speed, speed scale, lookahead,
// x limit, y limit; write only while the block is idle.
// Items pass a two-entry queue, then a sequencer executes one at a time.
// A query walks the waypoint RAM twice, then runs a bit-serial square root,
// two bit-serial divisions and a 20-step CORDIC. An empty path returns at
// once; a reached goal returns after the last point alone has been checked.
// Reset empties the path and progress index and loads register defaults.
// When m_tready is low the result holds in the output register; the queue
// keeps taking items until full, then s_tready drops.
module omni_lookahead_path_tracker import olpt_pkg::*; #(
	parameter int MAX_POINTS = OLPT_MAX_POINTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // pos_x, pos_y, heading
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // vel_body_x, vel_body_y, target_slot
	output logic [1:0]  m_tuser,   // at_goal, no_path
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	olpt_cfg_t  cfg_q;
	logic       q_valid;
	olpt_item_t q_item;
	logic       q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.desired_speed  <= '0;
			cfg_q.speed_scale    <= 17'd65536;
			cfg_q.lookahead_dist <= '0;
			cfg_q.max_x_speed    <= '0;
			cfg_q.max_y_speed    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DESIRED_SPEED:  cfg_q.desired_speed  <= cfg_data[20:0];
				REG_SPEED_SCALE:    cfg_q.speed_scale    <= cfg_data[16:0];
				REG_LOOKAHEAD_DIST: cfg_q.lookahead_dist <= cfg_data;
				REG_MAX_X_SPEED:    cfg_q.max_x_speed    <= cfg_data[20:0];
				REG_MAX_Y_SPEED:    cfg_q.max_y_speed    <= cfg_data[20:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	olpt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	olpt_back #(
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

### design/olpt_ram.sv
module olpt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/olpt_front.sv
`include "assert_macros.svh"
module olpt_front import olpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        q_valid,
	output olpt_item_t  q_item,
	input  logic        q_pop
);

	olpt_item_t fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	olpt_item_t item;
	logic       push;

	assign s_tready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_comb begin
		item.kind    = olpt_classify(s_tuser);
		item.pos_x   = s_tdata[31:0];
		item.pos_y   = s_tdata[63:32];
		item.heading = s_tdata[79:64];
	end

	// type 3 carries nothing; dropped here
	assign push = s_tvalid && s_tready && (item.kind != KIND_NOP);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`OLPT_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid)
	`OLPT_ASSERT_IMP(a_push_room, push, cnt_q != 2'd2)

endmodule

### design/olpt_back.sv
`include "assert_macros.svh"
module olpt_back import olpt_pkg::*; #(
	parameter int MAX_POINTS = OLPT_MAX_POINTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  olpt_cfg_t   cfg,
	input  logic        q_valid,
	input  olpt_item_t  q_item,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	olpt_state_t state_q, state_n;
	olpt_phase_t phase_q;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] prog_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic [IW-1:0] target_q;
	logic [64:0]   bestd_q;
	logic [64:0]   g2_q;
	logic [47:0]   l2_q;
	logic [21:0]   speed_q;

	logic signed [31:0] px_q, py_q;
	logic signed [15:0] hd_q;
	logic signed [32:0] dx_q, dy_q, gdx_q, gdy_q, tdx_q, tdy_q;
	logic [63:0]        sqx_q, sqy_q;

	logic [65:0] rad_q;
	logic [34:0] srem_q;
	logic [32:0] root_q;
	logic [32:0] dist_q;
	logic [NUM_W-1:0] num_q, prod_y_q;
	logic [33:0] drem_q;
	logic [5:0]  step_q;
	logic        dsel_q;
	logic signed [21:0] vx_q, vy_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic signed [64:0] gx_q, gy_q;

	logic signed [31:0] res_vx_q, res_vy_q;
	logic               res_goal_q, res_none_q;
	logic [7:0]         res_slot_q;

	logic        ram_we;
	logic [63:0] ram_rdata;
	logic        out_load;

	olpt_ram #(
		.WIDTH(64),
		.DEPTH(MAX_POINTS)
	) u_way (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IW-1:0]),
		.wdata({q_item.pos_y, q_item.pos_x}),
		.raddr(idx_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	// walk decisions
	logic [64:0]   d2_c;
	logic [CW-1:0] last_c, idx_nx_c;
	logic          more_c, closer_c, hit_c, goal_c, near_c, fin_c;
	logic [IW-1:0] start_c, nbest_c;
	logic signed [32:0] sel_dx_c, sel_dy_c;
	logic [64:0]   sel_d2_c;

	always_comb begin
		d2_c     = {1'b0, sqx_q} + {1'b0, sqy_q};
		last_c   = cnt_q - CW'(1);
		idx_nx_c = idx_q + CW'(1);
		more_c   = idx_nx_c < cnt_q;
		start_c  = (CW'(prog_q) < last_c) ? prog_q : last_c[IW-1:0];
		closer_c = d2_c < bestd_q;
		nbest_c  = closer_c ? idx_q[IW-1:0] : best_q;
		hit_c    = d2_c >= {17'b0, l2_q};
		goal_c   = d2_c <= GOAL_D2;
		sel_dx_c = hit_c ? dx_q : gdx_q;
		sel_dy_c = hit_c ? dy_q : gdy_q;
		sel_d2_c = hit_c ? d2_c : g2_q;
		near_c   = sel_d2_c < NEAR_D2;
		fin_c    = (phase_q == PH_LOOK) && (hit_c || !more_c);
	end

	// sqrt digit
	logic [36:0] sr_c, st_c;
	logic        sge_c;
	always_comb begin
		sr_c  = {srem_q, rad_q[65:64]};
		st_c  = {2'b0, root_q, 2'b01};
		sge_c = sr_c >= st_c;
	end

	// divide step and result clamp
	logic [33:0]      dt_c, drem_n_c;
	logic             dge_c;
	logic [NUM_W-1:0] num_n_c;
	logic [20:0]      lim_c, qv_c;
	logic             neg_c;
	logic signed [21:0] v_c;
	always_comb begin
		dt_c     = {drem_q[32:0], num_q[NUM_W-1]};
		dge_c    = dt_c >= {1'b0, dist_q};
		drem_n_c = dge_c ? dt_c - {1'b0, dist_q} : dt_c;
		num_n_c  = {num_q[NUM_W-2:0], dge_c};
		lim_c    = dsel_q ? cfg.max_y_speed : cfg.max_x_speed;
		qv_c     = (num_n_c > NUM_W'(lim_c)) ? lim_c : num_n_c[20:0];
		neg_c    = dsel_q ? tdy_q[32] : tdx_q[32];
		v_c      = neg_c ? -$signed({1'b0, qv_c}) : $signed({1'b0, qv_c});
	end

	// quadrant pre-rotation
	logic [31:0] theta_c, thp_c, ru_c;
	logic [1:0]  qd_c;
	logic signed [33:0] x0_c, y0_c;
	always_comb begin
		theta_c = 32'd0 - {hd_q, 16'b0};
		thp_c   = theta_c + 32'h2000_0000;
		qd_c    = thp_c[31:30];
		ru_c    = theta_c - {qd_c, 30'b0};
		x0_c    = 34'(vx_q) <<< 8;
		y0_c    = 34'(vy_q) <<< 8;
	end

	logic [31:0] mtx_c, mty_c, mdx_c, mdy_c;
	always_comb begin
		mtx_c = tdx_q[32] ? 32'(-tdx_q) : tdx_q[31:0];
		mty_c = tdy_q[32] ? 32'(-tdy_q) : tdy_q[31:0];
		mdx_c = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
		mdy_c = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.kind == KIND_QUERY) begin
					state_n = (cnt_q == '0) ? ST_OUT : ST_RD;
				end
			end
			ST_RD:   state_n = ST_DIFF;
			ST_DIFF: state_n = ST_SQ;
			ST_SQ:   state_n = ST_EVAL;
			ST_EVAL: begin
				if (phase_q == PH_GOAL && goal_c) begin
					state_n = ST_OUT;
				end else if (fin_c) begin
					state_n = ST_SQRT;
				end else begin
					state_n = ST_RD;
				end
			end
			ST_SQRT: begin
				if (step_q == 6'd32) begin
					state_n = ST_MUL;
				end
			end
			ST_MUL: state_n = ST_DIV;
			ST_DIV: begin
				if (step_q == 6'(NUM_W - 1) && dsel_q) begin
					state_n = ST_ROT;
				end
			end
			ST_ROT: state_n = ST_CORDIC;
			ST_CORDIC: begin
				if (step_q == 6'(CORDIC_STEPS - 1)) begin
					state_n = ST_GAIN;
				end
			end
			ST_GAIN: state_n = ST_RND;
			ST_RND:  state_n = ST_OUT;
			ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == ST_IDLE) && q_valid;
		ram_we   = q_pop && (q_item.kind == KIND_APPEND) && (cnt_q < CW'(MAX_POINTS));
		out_load = (state_q == ST_OUT) && (!m_tvalid || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			prog_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (q_pop && q_item.kind == KIND_CLEAR) begin
				cnt_q  <= '0;
				prog_q <= '0;
			end
			if (ram_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (state_q == ST_EVAL && !more_c) begin
				if (phase_q == PH_FIRST) begin
					prog_q <= best_q;
				end else if (phase_q == PH_NEAR) begin
					prog_q <= nbest_c;
				end
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q       <= q_item.pos_x;
				py_q       <= q_item.pos_y;
				hd_q       <= q_item.heading;
				speed_q    <= 22'((38'(cfg.desired_speed) * 38'(cfg.speed_scale)) >> 16);
				l2_q       <= 48'(cfg.lookahead_dist) * 48'(cfg.lookahead_dist);
				idx_q      <= cnt_q - CW'(1);
				phase_q    <= PH_GOAL;
				res_vx_q   <= '0;
				res_vy_q   <= '0;
				res_goal_q <= 1'b0;
				res_none_q <= 1'b1;
				res_slot_q <= '0;
			end
			ST_DIFF: begin
				dx_q <= {ram_rdata[31], ram_rdata[31:0]} - {px_q[31], px_q};
				dy_q <= {ram_rdata[63], ram_rdata[63:32]} - {py_q[31], py_q};
			end
			ST_SQ: begin
				sqx_q <= mdx_c * mdx_c;
				sqy_q <= mdy_c * mdy_c;
			end
			ST_EVAL: begin
				case (phase_q)
					PH_GOAL: begin
						g2_q       <= d2_c;
						gdx_q      <= dx_q;
						gdy_q      <= dy_q;
						res_goal_q <= 1'b1;
						res_none_q <= 1'b0;
						res_slot_q <= 8'(last_c[IW-1:0]);
						idx_q      <= CW'(start_c);
						best_q     <= start_c;
						phase_q    <= PH_FIRST;
					end
					PH_FIRST: begin
						bestd_q <= d2_c;
						if (more_c) begin
							idx_q   <= idx_nx_c;
							phase_q <= PH_NEAR;
						end else begin
							idx_q   <= CW'(best_q);
							phase_q <= PH_LOOK;
						end
					end
					PH_NEAR: begin
						if (closer_c) begin
							bestd_q <= d2_c;
						end
						best_q <= nbest_c;
						if (more_c) begin
							idx_q <= idx_nx_c;
						end else begin
							idx_q   <= CW'(nbest_c);
							phase_q <= PH_LOOK;
						end
					end
					PH_LOOK: begin
						if (fin_c) begin
							target_q <= hit_c ? idx_q[IW-1:0] : last_c[IW-1:0];
							tdx_q    <= near_c ? gdx_q : sel_dx_c;
							tdy_q    <= near_c ? gdy_q : sel_dy_c;
							rad_q    <= {1'b0, near_c ? g2_q : sel_d2_c};
							srem_q   <= '0;
							root_q   <= '0;
							step_q   <= '0;
						end else begin
							idx_q <= idx_nx_c;
						end
					end
					default: phase_q <= PH_GOAL;
				endcase
			end
			ST_SQRT: begin
				srem_q <= sge_c ? 35'(sr_c - st_c) : sr_c[34:0];
				root_q <= {root_q[31:0], sge_c};
				rad_q  <= {rad_q[63:0], 2'b00};
				step_q <= step_q + 6'd1;
			end
			ST_MUL: begin
				dist_q   <= (root_q == '0) ? 33'd1 : root_q;
				num_q    <= NUM_W'(speed_q) * NUM_W'(mtx_c);
				prod_y_q <= NUM_W'(speed_q) * NUM_W'(mty_c);
				drem_q   <= '0;
				step_q   <= '0;
				dsel_q   <= 1'b0;
			end
			ST_DIV: begin
				if (step_q == 6'(NUM_W - 1)) begin
					if (dsel_q) begin
						vy_q <= v_c;
					end else begin
						vx_q <= v_c;
					end
					num_q  <= prod_y_q;
					drem_q <= '0;
					step_q <= '0;
					dsel_q <= 1'b1;
				end else begin
					num_q  <= num_n_c;
					drem_q <= drem_n_c;
					step_q <= step_q + 6'd1;
				end
			end
			ST_ROT: begin
				case (qd_c)
					2'd0: begin
						cx_q <= x0_c;
						cy_q <= y0_c;
					end
					2'd1: begin
						cx_q <= -y0_c;
						cy_q <= x0_c;
					end
					2'd2: begin
						cx_q <= -x0_c;
						cy_q <= -y0_c;
					end
					default: begin
						cx_q <= y0_c;
						cy_q <= -x0_c;
					end
				endcase
				cz_q   <= 34'($signed(ru_c));
				step_q <= '0;
			end
			ST_CORDIC: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - (cy_q >>> step_q[4:0]);
					cy_q <= cy_q + (cx_q >>> step_q[4:0]);
					cz_q <= cz_q - olpt_atan(step_q[4:0]);
				end else begin
					cx_q <= cx_q + (cy_q >>> step_q[4:0]);
					cy_q <= cy_q - (cx_q >>> step_q[4:0]);
					cz_q <= cz_q + olpt_atan(step_q[4:0]);
				end
				step_q <= step_q + 6'd1;
			end
			ST_GAIN: begin
				gx_q <= 65'(cx_q) * 65'(INV_GAIN);
				gy_q <= 65'(cy_q) * 65'(INV_GAIN);
			end
			ST_RND: begin
				res_vx_q   <= 32'((gx_q + (65'sd1 <<< 37)) >>> 38);
				res_vy_q   <= 32'((gy_q + (65'sd1 <<< 37)) >>> 38);
				res_goal_q <= 1'b0;
				res_none_q <= 1'b0;
				res_slot_q <= 8'(target_q);
			end
			default: begin
				res_slot_q <= res_slot_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {res_slot_q, res_vy_q, res_vx_q};
			m_tuser <= {res_none_q, res_goal_q};
		end
	end

	`OLPT_ASSERT(a_count_cap, cnt_q <= CW'(MAX_POINTS))
	`OLPT_ASSERT(a_prog_in_path, (cnt_q == '0 && prog_q == '0) || CW'(prog_q) < cnt_q)
	`OLPT_ASSERT_IMP(a_flags_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]))
	`OLPT_ASSERT_IMP(a_pop_idle_only, q_pop, state_q == ST_IDLE)

endmodule

### sim/tb.sv
module tb;
	import olpt_pkg::*;

	localparam int DEPTH = 256;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam longint ARCTAN [20] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304};

	typedef struct {
		logic [31:0] vx;
		logic [31:0] vy;
		logic        at_goal;
		logic        no_path;
		logic [7:0]  slot;
	} cmd_t;

	class path_scoreboard;
		int wx[DEPTH];
		int wy[DEPTH];
		int unsigned npts, prog;
		longint unsigned desired, scale, look, lim_x, lim_y;
		cmd_t cmd_q[$];
		int errors, queries, appends, goals, empties, cmds_seen;

		function new();
			npts = 0; prog = 0;
			desired = 0; scale = 65536; look = 0; lim_x = 0; lim_y = 0;
		endfunction

		function void write_reg(olpt_reg_t r, longint unsigned v);
			case (r)
				REG_DESIRED_SPEED:  desired = v & 21'h1FFFFF;
				REG_SPEED_SCALE:    scale = v & 17'h1FFFF;
				REG_LOOKAHEAD_DIST: look = v & 24'hFFFFFF;
				REG_MAX_X_SPEED:    lim_x = v & 21'h1FFFFF;
				REG_MAX_Y_SPEED:    lim_y = v & 21'h1FFFFF;
				default: ;
			endcase
		endfunction

		function bit [65:0] dist_sq(longint dx, longint dy);
			bit [65:0] ax, ay;
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			return ax * ax + ay * ay;
		endfunction

		function bit [32:0] root(bit [65:0] v);
			bit [32:0] r, c;
			bit [66:0] cc;
			r = 0;
			for (int b = 32; b >= 0; b--) begin
				c = r | (33'd1 << b);
				cc = c;
				if (cc * cc <= {1'b0, v}) r = c;
			end
			return r;
		endfunction

		function longint axis_vel(longint d, longint unsigned spd, longint unsigned den,
				longint unsigned lim);
			longint unsigned m;
			longint v;
			m = d < 0 ? -d : d;
			v = (spd * m) / den;
			if (v > longint'(lim)) v = lim;
			return d < 0 ? -v : v;
		endfunction

		function void steer(int px, int py, shortint hd, ref cmd_t r);
			int unsigned last, best, tgt;
			longint gdx, gdy, tdx, tdy, vx, vy, x, y, z, t, sx, sy;
			bit [65:0] g2, t2, bd, d, l2, lw;
			longint unsigned span, spd;
			bit [31:0] theta, q, ru;
			r = '{default: '0};
			if (npts == 0) begin
				r.no_path = 1;
				empties++;
				return;
			end
			last = npts - 1;
			gdx = longint'(wx[last]) - px;
			gdy = longint'(wy[last]) - py;
			g2 = dist_sq(gdx, gdy);
			if (g2 <= GOAL_D2) begin
				r.at_goal = 1;
				r.slot = last[7:0];
				goals++;
				return;
			end
			best = prog < last ? prog : last;
			bd = dist_sq(longint'(wx[best]) - px, longint'(wy[best]) - py);
			for (int unsigned i = best + 1; i < npts; i++) begin
				d = dist_sq(longint'(wx[i]) - px, longint'(wy[i]) - py);
				if (d < bd) begin
					bd = d;
					best = i;
				end
			end
			prog = best;
			lw = look;
			l2 = lw * lw;
			tgt = last;
			for (int unsigned i = best; i < npts; i++) begin
				if (dist_sq(longint'(wx[i]) - px, longint'(wy[i]) - py) >= l2) begin
					tgt = i;
					break;
				end
			end
			tdx = longint'(wx[tgt]) - px;
			tdy = longint'(wy[tgt]) - py;
			t2 = dist_sq(tdx, tdy);
			if (t2 < NEAR_D2) begin
				tdx = gdx; tdy = gdy; t2 = g2;
			end
			span = root(t2);
			if (span == 0) span = 1;
			spd = (desired * scale) >> 16;
			vx = axis_vel(tdx, spd, span, lim_x);
			vy = axis_vel(tdy, spd, span, lim_y);
			theta = 32'd0 - {hd, 16'd0};
			q = ((theta + 32'h2000_0000) >> 30) & 32'd3;
			x = vx * 256;
			y = vy * 256;
			for (int k = 0; k < q; k++) begin
				t = x; x = -y; y = t;
			end
			ru = theta - (q << 30);
			z = longint'(int'(ru));
			for (int i = 0; i < 20; i++) begin
				sx = y >>> i;
				sy = x >>> i;
				if (z >= 0) begin
					x -= sx; y += sy; z -= ARCTAN[i];
				end else begin
					x += sx; y -= sy; z += ARCTAN[i];
				end
			end
			x = (x * longint'(INV_GAIN) + (64'sd1 <<< 37)) >>> 38;
			y = (y * longint'(INV_GAIN) + (64'sd1 <<< 37)) >>> 38;
			r.vx = x[31:0];
			r.vy = y[31:0];
			r.slot = tgt[7:0];
		endfunction

		function void note_input(olpt_kind_t k, int px, int py, shortint hd);
			cmd_t r;
			case (k)
				KIND_CLEAR: begin
					npts = 0;
					prog = 0;
				end
				KIND_APPEND: begin
					appends++;
					if (npts < DEPTH) begin
						wx[npts] = px;
						wy[npts] = py;
						npts++;
					end
				end
				KIND_QUERY: begin
					queries++;
					steer(px, py, hd, r);
					cmd_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(cmd_t got);
			cmd_t e;
			cmds_seen++;
			if (cmd_q.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
				return;
			end
			e = cmd_q.pop_front();
			if (got.vx !== e.vx) begin
				$error("vel_body_x: expected %0d got %0d", $signed(e.vx), $signed(got.vx));
				errors++;
			end
			if (got.vy !== e.vy) begin
				$error("vel_body_y: expected %0d got %0d", $signed(e.vy), $signed(got.vy));
				errors++;
			end
			if (got.at_goal !== e.at_goal) begin
				$error("at_goal: expected %0d got %0d", e.at_goal, got.at_goal);
				errors++;
			end
			if (got.no_path !== e.no_path) begin
				$error("no_path: expected %0d got %0d", e.no_path, got.no_path);
				errors++;
			end
			if (got.slot !== e.slot) begin
				$error("target_slot: expected %0d got %0d", e.slot, got.slot);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	omni_lookahead_path_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	path_scoreboard sb = new();
	longint cycles = 0;
	int burst_left = 0;
	int items_sent = 0;
	int stall_mode = 0;
	int stall_left = 0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: check, then pick next tready from a shifting stall pattern
	always @(posedge clk) begin
		cmd_t got;
		if (m_tvalid && m_tready) begin
			got.vx = m_tdata[31:0];
			got.vy = m_tdata[63:32];
			got.slot = m_tdata[71:64];
			got.at_goal = m_tuser[0];
			got.no_path = m_tuser[1];
			sb.check_result(got);
		end
		if (cycles % 500 == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else begin
					if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 60);
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	task automatic send(olpt_kind_t k, int px, int py, shortint hd);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {hd, py, px};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(k, px, py, hd);
		burst_left--;
		items_sent++;
	endtask

	task automatic cfg_write(olpt_reg_t r, int unsigned v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v[23:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(r, v);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.cmd_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic cfg_all(int unsigned ds, int unsigned sc, int unsigned la,
			int unsigned mx, int unsigned my);
		settle();
		cfg_write(REG_DESIRED_SPEED, ds);
		cfg_write(REG_SPEED_SCALE, sc);
		cfg_write(REG_LOOKAHEAD_DIST, la);
		cfg_write(REG_MAX_X_SPEED, mx);
		cfg_write(REG_MAX_Y_SPEED, my);
		cfg_valid <= 1'b0;
	endtask

	function automatic int rnd_span(int unsigned half);
		return int'($urandom_range(0, 2 * half)) - int'(half);
	endfunction

	task automatic query_near();
		int unsigned idx;
		int px, py;
		int sel;
		sel = $urandom_range(0, 9);
		if (sb.npts == 0 || sel == 0) begin
			px = $urandom;
			py = $urandom;
		end else begin
			idx = (sel <= 2) ? sb.npts - 1 : $urandom_range(0, sb.npts - 1);
			px = sb.wx[idx];
			py = sb.wy[idx];
			if (sel <= 2) begin
				px += rnd_span(400);
				py += rnd_span(400);
			end else if (sel > 3) begin
				px += rnd_span(262144);
				py += rnd_span(262144);
			end
		end
		send(KIND_QUERY, px, py, shortint'($urandom));
	endtask

	task automatic path_run();
		int n, cx, cy;
		bit wide;
		if ($urandom_range(0, 4) != 0) send(KIND_CLEAR, $urandom, $urandom, shortint'($urandom));
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		wide = ($urandom_range(0, 7) == 0);
		cx = wide ? $urandom : rnd_span(4194304);
		cy = wide ? $urandom : rnd_span(4194304);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) send(KIND_NOP, $urandom, $urandom, shortint'($urandom));
			send(KIND_APPEND, cx, cy, shortint'($urandom));
			if (wide) begin
				cx = $urandom;
				cy = $urandom;
			end else begin
				cx += rnd_span(262144);
				cy += rnd_span(262144);
			end
		end
		repeat ($urandom_range(1, 6)) query_near();
	endtask

	initial begin
		int target;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults first, then moderate settings
		send(KIND_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF);
		cfg_all(65536, 65536, 131072, 49152, 49152);
		send(KIND_QUERY, 0, 0, 0);
		send(KIND_NOP, -1, -1, -1);
		send(KIND_APPEND, 32'sh8000_0000, 32'sh8000_0000, 0);
		send(KIND_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
		send(KIND_APPEND, 0, 0, 0);
		send(KIND_APPEND, 196608, -131072, 0);
		send(KIND_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000);
		send(KIND_QUERY, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF);
		send(KIND_QUERY, 0, 0, 16384);
		send(KIND_QUERY, 196608, -131072, 0);
		send(KIND_QUERY, 196608 + 300, -131072 - 300, -16384);
		send(KIND_QUERY, 65536, 65536, 8192);
		send(KIND_CLEAR, 0, 0, 0);
		send(KIND_QUERY, 0, 0, 0);
		send(KIND_APPEND, 0, 0, 0);
		send(KIND_QUERY, 5, 5, 0);
		send(KIND_QUERY, 700, 0, 0);
		send(KIND_CLEAR, -1, -1, -1);

		// fill beyond capacity, then query over the whole path
		for (int i = 0; i < DEPTH + 3; i++) send(KIND_APPEND, i * 32768, i * -16384, 0);
		send(KIND_QUERY, -65536, 65536, 1000);
		send(KIND_QUERY, 100 * 32768, 100 * -16384 + 50000, -1000);
		send(KIND_QUERY, 255 * 32768, 255 * -16384, 0);

		target = items_sent;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: cfg_all(0, 0, 0, 0, 0);
				1: cfg_all(1048576, 65536, 16777215, 1048576, 1048576);
				2: cfg_all(1048576, 131071, 0, 1048576, 1048576);
				3: cfg_all(131072, 65536, 262144, 1048576, 65536);
				4: cfg_all($urandom_range(0, 2097151), $urandom_range(0, 131071),
					$urandom_range(0, 16777215), $urandom_range(0, 2097151),
					$urandom_range(0, 2097151));
				default: cfg_all($urandom_range(0, 1048576), $urandom_range(0, 65536),
					$urandom_range(0, 600000), $urandom_range(0, 1048576),
					$urandom_range(0, 1048576));
			endcase
			target += 120;
			while (items_sent < target) path_run();
		end

		settle();
		repeat (200) @(posedge clk);
		$display("covered %0d transfers in: %0d queries, %0d appends, %0d results checked",
			items_sent, sb.queries, sb.appends, sb.cmds_seen);
		$display("at-goal results %0d, empty-path results %0d, mismatches %0d",
			sb.goals, sb.empties, sb.errors);
		if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
